// File: rtl/bds2_pkg.sv
`default_nettype none
package bds2_pkg;

  // Fixed widths of the ports and registers
  localparam int PIX_W      = 8;   // one channel of a pixel
  localparam int NUM_CH     = 4;   // channel lanes on the ports
  localparam int SUM_W      = PIX_W + 1;  // horizontal pair sum
  localparam int DIM_W      = 13;  // width / height registers
  localparam int CNT_W      = 3;   // channel count register
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DIM_W;
  localparam int CMP_W      = 15;  // room for positions, 2*dw and y+1

  localparam int QUEUE_DEPTH = 4;

  localparam int DEF_MAX_WIDTH    = 4096;
  localparam int DEF_MAX_CHANNELS = 4;

  // Register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd2;

  localparam logic [DIM_W-1:0] RST_SRC_WIDTH     = 13'd1;
  localparam logic [DIM_W-1:0] RST_SRC_HEIGHT    = 13'd1;
  localparam logic [CNT_W-1:0] RST_CHANNEL_COUNT = 3'd4;

  // What the back end has to do with one queued pair
  typedef struct packed {
    logic wr;    // top row of a block: store the pair sum
    logic rd;    // bottom row: fetch the stored sum and emit a pixel
    logic last;  // emitted pixel closes the image
  } bds2_flags_t;

endpackage
`default_nettype wire

// File: rtl/bds2_front.sv
`default_nettype none
module bds2_front #(
  parameter int MAX_WIDTH    = bds2_pkg::DEF_MAX_WIDTH,
  parameter int MAX_CHANNELS = bds2_pkg::DEF_MAX_CHANNELS,
  parameter int IW           = 1,
  parameter int XW           = 1
) (
  input  wire logic                                                  clk,
  input  wire logic                                                  rst,
  input  wire logic [bds2_pkg::DIM_W-1:0]                            src_width,
  input  wire logic [bds2_pkg::DIM_W-1:0]                            src_height,
  input  wire logic                                                  in_valid,
  input  wire logic                                                  in_stall,
  input  wire logic [bds2_pkg::NUM_CH-1:0][bds2_pkg::PIX_W-1:0]      in_pix,
  output      logic                                                  push,
  output      bds2_pkg::bds2_flags_t                                 push_flags,
  output      logic [IW-1:0]                                         push_idx,
  output      logic [MAX_CHANNELS-1:0][bds2_pkg::SUM_W-1:0]          push_pair
);
  import bds2_pkg::*;

  logic [XW-1:0]    x;
  logic [XW-1:0]    x_next;
  logic [DIM_W-1:0] y;
  logic [DIM_W-1:0] y_next;
  logic [MAX_CHANNELS-1:0][PIX_W-1:0] held;

  logic             acc;
  logic [DIM_W-1:0] w0, w, h, dw, dh;
  logic [CMP_W-1:0] xe, ye, we, he, dwe, dhe;
  logic             col_left, col_right, row_top, row_bot;
  logic [MAX_CHANNELS-1:0][PIX_W-1:0] left;

  assign acc = in_valid && !in_stall;

  always_comb begin
    w0 = (src_width == '0) ? DIM_W'(1) : src_width;
    w  = (int'(w0) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : w0;
    h  = (src_height == '0) ? DIM_W'(1) : src_height;
    dw = ((w >> 1) == '0) ? DIM_W'(1) : (w >> 1);
    dh = ((h >> 1) == '0) ? DIM_W'(1) : (h >> 1);
    xe  = CMP_W'(x);
    ye  = CMP_W'(y);
    we  = CMP_W'(w);
    he  = CMP_W'(h);
    dwe = CMP_W'(dw);
    dhe = CMP_W'(dh);

    if (w == DIM_W'(1)) begin
      col_left  = (xe == '0);
      col_right = (xe == '0);
    end else begin
      col_left  = (xe < (dwe << 1)) && !xe[0];
      col_right = (xe < (dwe << 1)) && xe[0];
    end
    if (h == DIM_W'(1)) begin
      row_top = (ye == '0);
      row_bot = (ye == '0);
    end else begin
      row_top = (ye < (dhe << 1)) && !ye[0];
      row_bot = (ye < (dhe << 1)) && ye[0];
    end

    // width 1: the left pixel is the current one
    for (int c = 0; c < MAX_CHANNELS; c++) begin
      left[c]      = col_left ? in_pix[c] : held[c];
      push_pair[c] = {1'b0, left[c]} + {1'b0, in_pix[c]};
    end

    push            = acc && col_right;
    push_flags.wr   = row_top;
    push_flags.rd   = row_bot;
    push_flags.last = ((xe >> 1) == (dwe - CMP_W'(1))) &&
                      ((ye >> 1) == (dhe - CMP_W'(1)));
    push_idx        = IW'(xe >> 1);

    if ((xe + CMP_W'(1)) >= we) begin
      x_next = '0;
      y_next = ((ye + CMP_W'(1)) >= he) ? '0 : DIM_W'(ye + CMP_W'(1));
    end else begin
      x_next = XW'(xe + CMP_W'(1));
      y_next = y;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x    <= '0;
      y    <= '0;
      held <= '0;
    end else if (acc) begin
      x <= x_next;
      y <= y_next;
      if (col_left) begin
        for (int c = 0; c < MAX_CHANNELS; c++) begin
          held[c] <= in_pix[c];
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/bds2_queue.sv
`default_nettype none
module bds2_queue #(
  parameter int W = 1
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] din,
  input  wire logic         pop,
  output      logic         full,
  output      logic         nonempty,
  output      logic [W-1:0] dout
);
  import bds2_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  logic [W-1:0]  slots [QUEUE_DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [PW:0]   count;

  assign full     = (count == (PW+1)'(QUEUE_DEPTH));
  assign nonempty = (count != '0);
  assign dout     = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + PW'(1);
      if (pop)  rptr <= rptr + PW'(1);
      unique case ({push, pop})
        2'b10:   count <= count + (PW+1)'(1);
        2'b01:   count <= count - (PW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/bds2_back.sv
`default_nettype none
module bds2_back #(
  parameter int MAX_CHANNELS = bds2_pkg::DEF_MAX_CHANNELS,
  parameter int IW           = 1,
  parameter int LINE_DEPTH   = 2
) (
  input  wire logic                                              clk,
  input  wire logic                                              rst,
  input  wire logic [bds2_pkg::CNT_W-1:0]                        channel_count,
  input  wire logic                                              q_valid,
  input  wire bds2_pkg::bds2_flags_t                             q_flags,
  input  wire logic [IW-1:0]                                     q_idx,
  input  wire logic [MAX_CHANNELS-1:0][bds2_pkg::SUM_W-1:0]      q_pair,
  output      logic                                              pop,
  output      logic                                              out_valid,
  input  wire logic                                              out_stall,
  output      logic [bds2_pkg::NUM_CH-1:0][bds2_pkg::PIX_W-1:0]  out_pix,
  output      logic                                              out_last
);
  import bds2_pkg::*;

  localparam int LW = MAX_CHANNELS * SUM_W;

  // pair-sum line buffer, one entry per output column
  logic [LW-1:0] line_mem [LINE_DEPTH];

  logic [MAX_CHANNELS-1:0][SUM_W-1:0] rdata;
  logic [MAX_CHANNELS-1:0][SUM_W-1:0] hold_pair;
  logic                               hold_bypass;
  logic [MAX_CHANNELS-1:0][SUM_W-1:0] top;
  logic                               slot_free;

  assign slot_free = !out_valid || !out_stall;
  assign pop       = q_valid && (!q_flags.rd || slot_free);
  // single-row source: the pair stored this cycle is its own top row
  assign top       = hold_bypass ? hold_pair : rdata;

  always_ff @(posedge clk) begin
    if (pop && q_flags.wr) begin
      line_mem[q_idx] <= q_pair;
    end
    if (pop && q_flags.rd) begin
      rdata       <= line_mem[q_idx];
      hold_pair   <= q_pair;
      hold_bypass <= q_flags.wr;
      out_last    <= q_flags.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && q_flags.rd) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  for (genvar c = 0; c < NUM_CH; c++) begin : g_ch
    if (c < MAX_CHANNELS) begin : g_used
      logic [SUM_W:0] quad;
      assign quad       = {1'b0, hold_pair[c]} + {1'b0, top[c]};
      assign out_pix[c] = (CNT_W'(c) < channel_count) ? quad[SUM_W:2] : '0;
    end else begin : g_unused
      assign out_pix[c] = '0;
    end
  end

endmodule
`default_nettype wire

// File: rtl/box_downsample_2x2_core.sv
`default_nettype none
// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+-------------------------------------
// config    | in        | cfg_write            | cfg_index, cfg_data
// source px | in        | in_valid / in_stall  | in_chan0..in_chan3
// mip px    | out       | out_valid / out_stall| out_chan0..out_chan3, last_pixel
//
// One source pixel per clock while in_stall is low; the front end classifies a pixel
// combinationally and the line buffer does at most one read and one write per clock.
// A bottom-right pixel is written to a queue slot, then popped with its line buffer
// read into the output stage registers once that stage is free, and leaves from there.
// rst is synchronous; the line buffer is not cleared and needs no sweep.
// in_stall rises only when the 4-deep request queue is full; out_stall holds the output stage.
module box_downsample_2x2_core #(
  parameter int MAX_WIDTH    = bds2_pkg::DEF_MAX_WIDTH,
  parameter int MAX_CHANNELS = bds2_pkg::DEF_MAX_CHANNELS
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_write,
  input  wire logic [bds2_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [bds2_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  wire logic                              in_valid,
  output      logic                              in_stall,
  input  wire logic [bds2_pkg::PIX_W-1:0]        in_chan0,
  input  wire logic [bds2_pkg::PIX_W-1:0]        in_chan1,
  input  wire logic [bds2_pkg::PIX_W-1:0]        in_chan2,
  input  wire logic [bds2_pkg::PIX_W-1:0]        in_chan3,
  output      logic                              out_valid,
  input  wire logic                              out_stall,
  output      logic [bds2_pkg::PIX_W-1:0]        out_chan0,
  output      logic [bds2_pkg::PIX_W-1:0]        out_chan1,
  output      logic [bds2_pkg::PIX_W-1:0]        out_chan2,
  output      logic [bds2_pkg::PIX_W-1:0]        out_chan3,
  output      logic                              last_pixel
);
  import bds2_pkg::*;

  // Line buffer holds one pair sum per output column
  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int IW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int FW = $bits(bds2_flags_t);
  localparam int PAIR_W = MAX_CHANNELS * SUM_W;
  localparam int QW = FW + IW + PAIR_W;

  // Configuration registers
  logic [DIM_W-1:0] src_width;
  logic [DIM_W-1:0] src_height;
  logic [CNT_W-1:0] channel_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width     <= RST_SRC_WIDTH;
      src_height    <= RST_SRC_HEIGHT;
      channel_count <= RST_CHANNEL_COUNT;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SRC_WIDTH:     src_width     <= cfg_data;
        REG_SRC_HEIGHT:    src_height    <= cfg_data;
        REG_CHANNEL_COUNT: channel_count <= cfg_data[CNT_W-1:0];
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // Front end: position tracking, left-pixel hold, pair sums
  logic [NUM_CH-1:0][PIX_W-1:0]       in_pix;
  logic                               f_push;
  bds2_flags_t                        f_flags;
  logic [IW-1:0]                      f_idx;
  logic [MAX_CHANNELS-1:0][SUM_W-1:0] f_pair;

  assign in_pix = {in_chan3, in_chan2, in_chan1, in_chan0};

  bds2_front #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS),
    .IW           (IW),
    .XW           (XW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .src_width  (src_width),
    .src_height (src_height),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_pix     (in_pix),
    .push       (f_push),
    .push_flags (f_flags),
    .push_idx   (f_idx),
    .push_pair  (f_pair)
  );

  // Request queue between front and back
  logic          q_full;
  logic          q_nonempty;
  logic          q_pop;
  logic [QW-1:0] q_dout;

  assign in_stall = q_full;

  bds2_queue #(
    .W (QW)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (f_push),
    .din      ({f_flags, f_idx, f_pair}),
    .pop      (q_pop),
    .full     (q_full),
    .nonempty (q_nonempty),
    .dout     (q_dout)
  );

  // Back end: line buffer access, 2x2 average, output stage
  bds2_flags_t                        b_flags;
  logic [IW-1:0]                      b_idx;
  logic [MAX_CHANNELS-1:0][SUM_W-1:0] b_pair;
  logic [NUM_CH-1:0][PIX_W-1:0]       out_pix;

  assign b_flags = q_dout[QW-1 -: FW];
  assign b_idx   = q_dout[PAIR_W +: IW];
  assign b_pair  = q_dout[PAIR_W-1:0];

  bds2_back #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .IW           (IW),
    .LINE_DEPTH   (LINE_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .channel_count (channel_count),
    .q_valid       (q_nonempty),
    .q_flags       (b_flags),
    .q_idx         (b_idx),
    .q_pair        (b_pair),
    .pop           (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_pix       (out_pix),
    .out_last      (last_pixel)
  );

  assign out_chan0 = out_pix[0];
  assign out_chan1 = out_pix[1];
  assign out_chan2 = out_pix[2];
  assign out_chan3 = out_pix[3];

endmodule
`default_nettype wire
